@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/hrt_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request head tokenizer package
// Field codes, status codes and the result and run types shared by the block.
// ----------------------------------------------------------------------------
package hrt_pkg;

  // Field kinds, which double as the parse phase codes.
  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URL     = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_KEY     = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_COLON  = 2'd1;
  localparam logic [1:0] ST_SHORT_REQ = 2'd2;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  // Most results one input byte can cause.
  localparam int MAX_RES = 3;

  // Run queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       byte_valid;
    logic       field_end;
    logic       request_done;
    logic [1:0] status;
  } res_t;

  // All results caused by one input byte, oldest in slot 0.
  typedef struct packed {
    res_t [MAX_RES-1:0] slot;
    logic [1:0]         count;
  } run_t;

  // Head of the run queue as seen by the back end.
  typedef struct packed {
    logic valid;
    run_t run;
  } head_t;

endpackage

@@ rtl/hrt_front.sv @@
// ----------------------------------------------------------------------------
// HTTP tokenizer front end
// Holds the parse state, classifies each byte and builds its run of results.
// ----------------------------------------------------------------------------
module hrt_front import hrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       enq,
  output run_t       run
);

  logic [2:0] phase_r, phase_nxt;
  logic [1:0] pstage_r, pstage_nxt;
  logic [3:0] hdig_r, hdig_nxt;
  logic       hlower_r, hlower_nxt;
  logic       hcr_r, hcr_nxt;
  logic       hcolon_r, hcolon_nxt;
  logic       lhb_r, lhb_nxt;

  logic       is_hex;
  logic [3:0] hex_val;
  logic [7:0] held_char;
  logic       handled;

  function automatic run_t run_put(run_t r, res_t x);
    run_t o;
    o = r;
    if (r.count < 2'(MAX_RES)) begin
      o.slot[r.count] = x;
      o.count = r.count + 2'd1;
    end
    return o;
  endfunction

  function automatic res_t mk_data(logic [7:0] b, logic [2:0] kind);
    res_t x;
    x.data = b;
    x.kind = kind;
    x.byte_valid = 1'b1;
    x.field_end = 1'b0;
    x.request_done = 1'b0;
    x.status = ST_OK;
    return x;
  endfunction

  function automatic res_t mk_end(logic [2:0] kind, logic [1:0] st);
    res_t x;
    x.data = 8'd0;
    x.kind = kind;
    x.byte_valid = 1'b0;
    x.field_end = 1'b1;
    x.request_done = 1'b0;
    x.status = st;
    return x;
  endfunction

  function automatic res_t mk_done();
    res_t x;
    x.data = 8'd0;
    x.kind = KIND_KEY;
    x.byte_valid = 1'b0;
    x.field_end = 1'b0;
    x.request_done = 1'b1;
    x.status = ST_OK;
    return x;
  endfunction

  always_comb begin
    is_hex = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h61 + 8'd10);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h41 + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Held digit of a broken escape, restored in its original case.
  always_comb begin
    if (hdig_r < 4'd10) begin
      held_char = 8'h30 + {4'd0, hdig_r};
    end else begin
      held_char = (hlower_r ? 8'h61 : 8'h41) + {4'd0, hdig_r} - 8'd10;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    pstage_nxt = pstage_r;
    hdig_nxt   = hdig_r;
    hlower_nxt = hlower_r;
    hcr_nxt    = hcr_r;
    hcolon_nxt = hcolon_r;
    lhb_nxt    = lhb_r;
    run        = '0;
    handled    = 1'b0;

    if (hcr_r && in_byte == CH_LF) begin
      // CRLF ends the line.
      unique case (phase_r)
        KIND_METHOD: begin
          if (lhb_r) begin
            run = run_put(run, mk_end(KIND_METHOD, ST_SHORT_REQ));
            phase_nxt = KIND_KEY;
          end
        end
        KIND_URL: begin
          run = run_put(run, mk_end(KIND_URL, ST_SHORT_REQ));
          phase_nxt = KIND_KEY;
        end
        KIND_VERSION: begin
          run = run_put(run, mk_end(KIND_VERSION, ST_OK));
          phase_nxt = KIND_KEY;
        end
        KIND_KEY: begin
          if (lhb_r) begin
            run = run_put(run, mk_end(KIND_KEY, ST_NO_COLON));
          end else begin
            run = run_put(run, mk_done());
            phase_nxt = KIND_METHOD;
          end
        end
        default: begin
          run = run_put(run, mk_end(KIND_VALUE, ST_OK));
          phase_nxt = KIND_KEY;
        end
      endcase
      lhb_nxt    = 1'b0;
      hcr_nxt    = 1'b0;
      hcolon_nxt = 1'b0;
      pstage_nxt = 2'd0;
    end else begin
      if (hcr_r) begin
        // A lone CR is field data.
        run = run_put(run, mk_data(CH_CR, (phase_r <= KIND_VALUE) ? phase_r : KIND_VALUE));
        lhb_nxt = 1'b1;
        hcr_nxt = 1'b0;
      end

      if (in_byte == CH_CR) begin
        if (phase_r == KIND_URL) begin
          if (pstage_nxt != 2'd0) begin
            run = run_put(run, mk_data(CH_PERCENT, KIND_URL));
          end
          if (pstage_nxt == 2'd2) begin
            run = run_put(run, mk_data(held_char, KIND_URL));
          end
          pstage_nxt = 2'd0;
        end
        if (phase_r == KIND_KEY && hcolon_nxt) begin
          run = run_put(run, mk_data(CH_COLON, KIND_KEY));
          hcolon_nxt = 1'b0;
        end
        hcr_nxt = 1'b1;
      end else begin
        lhb_nxt = 1'b1;
        unique case (phase_r)
          KIND_METHOD: begin
            if (in_byte == CH_SPACE) begin
              run = run_put(run, mk_end(KIND_METHOD, ST_OK));
              phase_nxt = KIND_URL;
            end else begin
              run = run_put(run, mk_data(in_byte, KIND_METHOD));
            end
          end
          KIND_URL: begin
            if (pstage_r == 2'd1 && is_hex) begin
              hdig_nxt   = hex_val;
              hlower_nxt = (in_byte >= 8'h61);
              pstage_nxt = 2'd2;
            end else if (pstage_r == 2'd2 && is_hex) begin
              run = run_put(run, mk_data({hdig_r, hex_val}, KIND_URL));
              pstage_nxt = 2'd0;
            end else begin
              // Anything else breaks a pending escape, which passes through.
              if (pstage_r != 2'd0) begin
                run = run_put(run, mk_data(CH_PERCENT, KIND_URL));
              end
              if (pstage_r == 2'd2) begin
                run = run_put(run, mk_data(held_char, KIND_URL));
              end
              pstage_nxt = 2'd0;
              if (in_byte == CH_PERCENT) begin
                pstage_nxt = 2'd1;
              end else if (in_byte == CH_SPACE) begin
                run = run_put(run, mk_end(KIND_URL, ST_OK));
                phase_nxt = KIND_VERSION;
              end else begin
                run = run_put(run, mk_data(in_byte, KIND_URL));
              end
            end
          end
          KIND_VERSION: begin
            run = run_put(run, mk_data(in_byte, KIND_VERSION));
          end
          KIND_KEY: begin
            if (hcolon_r) begin
              hcolon_nxt = 1'b0;
              if (in_byte == CH_SPACE) begin
                run = run_put(run, mk_end(KIND_KEY, ST_OK));
                phase_nxt = KIND_VALUE;
                handled = 1'b1;
              end else begin
                run = run_put(run, mk_data(CH_COLON, KIND_KEY));
              end
            end
            if (!handled) begin
              if (in_byte == CH_COLON) begin
                hcolon_nxt = 1'b1;
              end else begin
                run = run_put(run, mk_data(in_byte, KIND_KEY));
              end
            end
          end
          default: begin
            run = run_put(run, mk_data(in_byte, KIND_VALUE));
          end
        endcase
      end
    end
  end

  assign enq = accept && (run.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= KIND_METHOD;
      pstage_r <= 2'd0;
      hdig_r   <= 4'd0;
      hlower_r <= 1'b0;
      hcr_r    <= 1'b0;
      hcolon_r <= 1'b0;
      lhb_r    <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pstage_r <= pstage_nxt;
      hdig_r   <= hdig_nxt;
      hlower_r <= hlower_nxt;
      hcr_r    <= hcr_nxt;
      hcolon_r <= hcolon_nxt;
      lhb_r    <= lhb_nxt;
    end
  end

endmodule

@@ rtl/hrt_run_queue.sv @@
// ----------------------------------------------------------------------------
// HTTP tokenizer run queue
// Short queue of result runs that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module hrt_run_queue import hrt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  enq,
  input  run_t  enq_run,
  input  logic  deq,
  output logic  full,
  output head_t head
);

  run_t              store_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.run   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (enq) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      count_nxt = count_r + 1'b1;
    end else if (!enq && deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      store_r[wr_ptr_r] <= enq_run;
    end
  end

endmodule

@@ rtl/hrt_back.sv @@
// ----------------------------------------------------------------------------
// HTTP tokenizer back end
// Walks the head run one result at a time and presents it on the result port.
// ----------------------------------------------------------------------------
module hrt_back import hrt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  head_t head,
  input  logic  pop,
  output logic  deq,
  output logic  empty,
  output res_t  cur,
  output logic  last
);

  logic [1:0] idx_r, idx_nxt;
  logic       take;

  assign empty = !head.valid;
  assign cur   = head.run.slot[idx_r];
  assign last  = (idx_r == head.run.count - 2'd1);
  assign take  = pop && head.valid;
  assign deq   = take && last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ rtl/http_request_head_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// HTTP request head tokenizer
// Splits a request head into tagged method, URL, version, key and value bytes.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever full is low; full rises only when all
// four entries of the run queue between the parser and the result port are
// occupied. Each byte yields zero to three results, which leave the result
// port one per cycle while pop is high, so the sustained rate is one byte per
// cycle for bytes with at most one result and is set by the result port, one
// result per pop, otherwise. A byte's run is registered behind older runs.
`include "assert_macros.svh"

module http_request_head_tokenizer_core import hrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] out_field_kind,
  output logic       out_byte_valid,
  output logic       out_field_end,
  output logic       out_request_done,
  output logic [1:0] out_parse_status,
  output logic       out_last_of_run
);

  logic  accept;
  logic  enq;
  run_t  run;
  logic  deq;
  head_t head;
  res_t  cur;

  assign accept = push && !full;

  hrt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .enq     (enq),
    .run     (run)
  );

  hrt_run_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_run (run),
    .deq     (deq),
    .full    (full),
    .head    (head)
  );

  hrt_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .deq   (deq),
    .empty (empty),
    .cur   (cur),
    .last  (out_last_of_run)
  );

  assign out_byte         = cur.data;
  assign out_field_kind   = cur.kind;
  assign out_byte_valid   = cur.byte_valid;
  assign out_field_end    = cur.field_end;
  assign out_request_done = cur.request_done;
  assign out_parse_status = cur.status;

  `ASSERT_IMPLY(a_marker_zero, !empty && !out_byte_valid, out_byte == 8'd0, "marker with data")
  `ASSERT_IMPLY(a_status_on_end, !empty && out_parse_status != ST_OK, out_field_end, "status off end")
  `ASSERT_IMPLY(a_done_form, !empty && out_request_done, out_field_kind == KIND_KEY && !out_field_end, "bad done marker")
  `ASSERT_NEXT(a_run_continues, pop && !empty && !out_last_of_run, !empty, "run cut short")

endmodule
